/* hdl/generational_handle_allocator_top_macros.svh */
// Assertion macros shared by the allocator modules.
// Each macro expects clk and arst_n to exist in the module that uses it.
`ifndef GENERATIONAL_HANDLE_ALLOCATOR_TOP_MACROS_SVH
`define GENERATIONAL_HANDLE_ALLOCATOR_TOP_MACROS_SVH

// Same-cycle implication, disabled while reset is applied.
`define GHA_ASSERT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is applied.
`define GHA_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* hdl/gha_pkg.sv */
package gha_pkg;

	// Field widths of the item and result.
	localparam int ACT_W = 2;
	localparam int IDX_W = 10;
	localparam int GEN_W = 32;

	typedef logic [ACT_W-1:0] action_t;
	typedef logic [IDX_W-1:0] hidx_t;
	typedef logic [GEN_W-1:0] gen_t;

	// Action codes.
	localparam action_t ACT_CREATE  = 2'd0;
	localparam action_t ACT_DESTROY = 2'd1;
	localparam action_t ACT_CHECK   = 2'd2;

	// Stack update request from the execute logic.
	typedef struct packed {
		logic pop;
		logic push;
	} stk_ctl_t;

	// Stack status seen by the execute logic.
	typedef struct packed {
		logic nonempty;
		logic notfull;
	} stk_stat_t;

	// Next generation after a live one; the wrap skips zero.
	function automatic gen_t gen_bump(input gen_t g);
		gen_t r;
		if (g == '1) begin
			r = gen_t'(1);
		end else begin
			r = g + gen_t'(1);
		end
		return r;
	endfunction

endpackage

/* hdl/gha_gen_table.sv */
module gha_gen_table #(
	parameter int SLOTS = 1024,
	localparam int SW = $clog2(SLOTS)
) (
	input  logic            clk,
	input  logic            we,
	input  logic [SW-1:0]   waddr,
	input  gha_pkg::gen_t   wdata,
	input  logic            re,
	input  logic [SW-1:0]   raddr,
	output gha_pkg::gen_t   rdata
);
	import gha_pkg::*;

	// Live generation per slot. Entries are only trusted once the slot has
	// been handed out; the caller masks untouched slots to zero.
	gen_t live_mem [SLOTS];
	gen_t rdata_s1;

	// Single write port, one registered read port with write-first bypass.
	always_ff @(posedge clk) begin
		if (we) begin
			live_mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_s1 <= (we && (waddr == raddr)) ? wdata : live_mem[raddr];
		end
	end

	assign rdata = rdata_s1;

endmodule

/* hdl/gha_free_stack.sv */
`include "generational_handle_allocator_top_macros.svh"

module gha_slot_stack #(
	parameter int SLOTS = 1024,
	localparam int SW = $clog2(SLOTS),
	localparam int CW = $clog2(SLOTS + 1)
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                rd_en,
	input  gha_pkg::stk_ctl_t   ctl,
	input  logic [SW-1:0]       push_slot,
	input  gha_pkg::gen_t       push_gen,
	output gha_pkg::stk_stat_t  stat,
	output logic [SW-1:0]       top_slot,
	output gha_pkg::gen_t       top_gen,
	output logic [CW-1:0]       fresh
);
	import gha_pkg::*;

	localparam int EW = SW + GEN_W;

	// Each entry keeps a free slot together with the generation it gets
	// when it is handed out again.
	logic [EW-1:0] stk_mem [SLOTS];
	logic [EW-1:0] top_s1;

	// Depth of the stack, and the number of slots ever handed out.
	// Positions below SLOTS-fresh_q have never been written; after reset
	// position p stands for slot SLOTS-1-p, so a pop at that boundary yields
	// slot fresh_q.
	logic [CW-1:0] count_q;
	logic [CW-1:0] fresh_q;
	logic [CW-1:0] count_d;
	logic [CW-1:0] fresh_d;
	logic [CW-1:0] rpos;
	logic          fresh_pop;
	logic [SW-1:0] waddr;
	logic [SW-1:0] raddr;
	logic [EW-1:0] wdata;

	assign fresh_pop = (({1'b0, count_q} + {1'b0, fresh_q}) == (CW+1)'(SLOTS));
	assign count_d   = count_q - CW'(ctl.pop) + CW'(ctl.push);
	assign fresh_d   = fresh_q + CW'(ctl.pop && fresh_pop);

	// The next top of stack is read as the item is taken in.
	assign rpos  = count_d - CW'(1);
	assign raddr = rpos[SW-1:0];
	assign waddr = count_q[SW-1:0];
	assign wdata = {push_slot, push_gen};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= CW'(SLOTS);
			fresh_q <= '0;
		end else begin
			count_q <= count_d;
			fresh_q <= fresh_d;
		end
	end

	// Stack storage with write-first read.
	always_ff @(posedge clk) begin
		if (ctl.push) begin
			stk_mem[waddr] <= wdata;
		end
		if (rd_en) begin
			top_s1 <= (ctl.push && (waddr == raddr)) ? wdata : stk_mem[raddr];
		end
	end

	// Top of stack: a never-used slot starts at generation one.
	assign top_slot = fresh_pop ? fresh_q[SW-1:0] : top_s1[EW-1 -: SW];
	assign top_gen  = fresh_pop ? gen_t'(1) : top_s1[GEN_W-1:0];

	assign stat.nonempty = (count_q != '0);
	assign stat.notfull  = (count_q != CW'(SLOTS));
	assign fresh         = fresh_q;

	`GHA_ASSERT(a_stk_low_mark, 1'b1,
		({1'b0, count_q} + {1'b0, fresh_q}) >= (CW+1)'(SLOTS),
		"stack depth fell below the never-used region")
	`GHA_ASSERT(a_stk_pop_nonempty, ctl.pop, count_q != '0, "pop from an empty stack")
	`GHA_ASSERT_NEXT(a_stk_fresh_step, ctl.pop && fresh_pop,
		fresh_q == $past(fresh_q) + CW'(1), "fresh slot count did not advance")

endmodule

/* hdl/generational_handle_allocator_top.sv */
// Generational handle allocator.
// Input channel (in_valid/in_ready) carries one request item: action selects
// create, destroy or check; handle_index and handle_gen name the handle.
// Output channel (out_valid/out_ready) returns one result item per request:
// ok, out_index (the new slot on create, else the echoed index) and out_gen
// (the new generation on create, else zero).
// A request passes through the request register, where the stack top and
// the slot's live generation are already read, and then the result
// register, which presents the result. One item is accepted every cycle
// while out_ready is held high; that rate is set by the single read and
// write port of the free slot stack memory and of the generation memory,
// with write-first bypass.
// After reset all SLOTS slots are free and are handed out in order 0, 1, 2
// and so on; every slot reads as dead. No clearing pass is needed, so
// requests are taken from the first cycle after reset.
// When the receiver holds out_ready low, the result register holds its item,
// the request register fills, and in_ready drops until the result is taken.
`include "generational_handle_allocator_top_macros.svh"

module generational_handle_allocator_top #(
	parameter int SLOTS = 1024
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  gha_pkg::action_t  action,
	input  gha_pkg::hidx_t    handle_index,
	input  gha_pkg::gen_t     handle_gen,
	output logic              out_valid,
	input  logic              out_ready,
	output logic              ok,
	output gha_pkg::hidx_t    out_index,
	output gha_pkg::gen_t     out_gen
);
	import gha_pkg::*;

	localparam int SW = $clog2(SLOTS);
	localparam int CW = $clog2(SLOTS + 1);

	logic      in_fire;
	logic      s1_fire;
	logic      s1_valid_q;
	action_t   action_s1;
	hidx_t     idx_s1;
	gen_t      gen_s1;

	logic      out_valid_q;
	logic      ok_q;
	hidx_t     out_index_q;
	gen_t      out_gen_q;

	stk_ctl_t  ctl;
	stk_ctl_t  ctl_g;
	stk_stat_t stat;
	logic [SW-1:0] top_slot;
	gen_t      top_gen;
	logic [CW-1:0] fresh;

	logic      we;
	logic      we_g;
	logic [SW-1:0] waddr;
	gen_t      wdata;
	gen_t      live_rd;
	gen_t      live_cur;
	logic      is_live;

	logic      res_ok;
	hidx_t     res_idx;
	gen_t      res_gen;

	// Handshake: the request register advances whenever the result register
	// is free or being emptied.
	assign s1_fire  = s1_valid_q && (!out_valid_q || out_ready);
	assign in_ready = !s1_valid_q || s1_fire;
	assign in_fire  = in_valid && in_ready;

	// Request register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (in_ready) begin
			s1_valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			action_s1 <= action;
			idx_s1    <= handle_index;
			gen_s1    <= handle_gen;
		end
	end

	// Free slot stack.
	gha_slot_stack #(.SLOTS(SLOTS)) u_stack (
		.clk       (clk),
		.arst_n    (arst_n),
		.rd_en     (in_fire),
		.ctl       (ctl_g),
		.push_slot (SW'(idx_s1)),
		.push_gen  (gen_bump(live_cur)),
		.stat      (stat),
		.top_slot  (top_slot),
		.top_gen   (top_gen),
		.fresh     (fresh)
	);

	// Live generation per slot.
	gha_gen_table #(.SLOTS(SLOTS)) u_gen (
		.clk   (clk),
		.we    (we_g),
		.waddr (waddr),
		.wdata (wdata),
		.re    (in_fire),
		.raddr (SW'(handle_index)),
		.rdata (live_rd)
	);

	// A slot never handed out is dead; this also covers indexes past SLOTS.
	assign live_cur = (32'(idx_s1) < 32'(fresh)) ? live_rd : '0;
	assign is_live  = (gen_s1 != '0) && (live_cur == gen_s1);

	// Execute the request held in the request register.
	always_comb begin
		gen_t g;
		g       = (top_gen == '0) ? gen_t'(1) : top_gen;
		res_ok  = 1'b0;
		res_idx = idx_s1;
		res_gen = '0;
		ctl     = '0;
		we      = 1'b0;
		waddr   = SW'(idx_s1);
		wdata   = '0;
		unique case (action_s1)
			ACT_CREATE: begin
				if (stat.nonempty) begin
					ctl.pop = 1'b1;
					we      = 1'b1;
					waddr   = top_slot;
					wdata   = g;
					res_ok  = 1'b1;
					res_idx = IDX_W'(top_slot);
					res_gen = g;
				end
			end
			ACT_DESTROY: begin
				if (is_live) begin
					we       = 1'b1;
					ctl.push = stat.notfull;
					res_ok   = 1'b1;
				end
			end
			ACT_CHECK: begin
				res_ok = is_live;
			end
			default: begin
			end
		endcase
	end

	// State changes only when the request moves to the result register.
	assign ctl_g.pop  = ctl.pop && s1_fire;
	assign ctl_g.push = ctl.push && s1_fire;
	assign we_g       = we && s1_fire;

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s1_fire) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_fire) begin
			ok_q        <= res_ok;
			out_index_q <= res_idx;
			out_gen_q   <= res_gen;
		end
	end

	assign out_valid = out_valid_q;
	assign ok        = ok_q;
	assign out_index = out_index_q;
	assign out_gen   = out_gen_q;

	`GHA_ASSERT(a_stall_only_behind_result, s1_valid_q && !s1_fire,
		out_valid_q && !out_ready, "request held without a stalled result")
	`GHA_ASSERT(a_gen_only_on_success, out_valid_q && (out_gen_q != '0), ok_q,
		"nonzero generation returned without success")
	`GHA_ASSERT_NEXT(a_result_follows, s1_fire, out_valid_q,
		"request moved on but no result was presented")

endmodule
